### rtl/vbr_pkg.sv
`default_nettype none

package vbr_pkg;

    localparam int INTERVALS    = 32;
    localparam int TOP_SEGMENTS = 3;
    localparam int COUNT_WIDTH  = 16;

    localparam int TONES = 12;

    // Fixed field widths of the two channels.
    localparam int IVL_W     = 5;
    localparam int TON_W     = 4;
    localparam int SUM_OUT_W = 18;
    localparam logic [SUM_OUT_W-1:0] SUM_MAX = '1;

    localparam int ADDR_W = (INTERVALS > 1) ? $clog2(INTERVALS) : 1;
    localparam int CNT_W  = $clog2(INTERVALS + 1);
    localparam int ROW_W  = TONES * COUNT_WIDTH;
    localparam int SUM_W  = COUNT_WIDTH + $clog2(TOP_SEGMENTS);
    localparam int EXT_W  = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [SUM_W-1:0]       lane_sum_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [TON_W-1:0]       ton_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  vote_en;
        addr_t scan_addr;
        logic  lane_clr;
        logic  ins_en;
        logic  pick_en;
        logic  pick_first;
        ton_t  pick_idx;
        logic  emit;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

### rtl/vote_bag_top_segment_ranker_top.sv
`default_nettype none

// Vote bag ranker. Vote beats (func 0) arrive on the vote channel and each
// adds one to the count at its interval and tonality, saturating; votes
// out of range are dropped. Votes are taken one per cycle, back to back,
// while vote_stall is low. A finish beat (func 1) makes the block walk
// the count store one interval row per cycle, keeping the three largest
// counts of each of the twelve tonalities, then compare the twelve sums
// one per cycle and load the result beat on the rank channel. The store
// is cleared when the result is loaded, so the next song starts from
// zero. vote_stall is high from the finish beat until the result is
// loaded, and the next beat is taken in the cycle after that. A stalled
// result holds and votes still enter while it waits. A second finish is
// scanned meanwhile, but its result, with vote_stall still high, waits
// until the first result is taken.
// Reset clears the store (through per-row valid bits) and the channels.
module vote_bag_top_segment_ranker_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            vote_valid,
    output logic                            vote_stall,
    input  logic                            func,
    input  logic [vbr_pkg::IVL_W-1:0]       interval,
    input  logic [vbr_pkg::TON_W-1:0]       tonality,
    output logic                            rank_valid,
    input  logic                            rank_stall,
    output logic [vbr_pkg::TON_W-1:0]       best_tonality,
    output logic [vbr_pkg::IVL_W-1:0]       best_segment,
    output logic [vbr_pkg::SUM_OUT_W-1:0]   top_sum
);
    import vbr_pkg::*;

    cmd_t    cmd;
    status_t status;

    vbr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .vote_valid (vote_valid),
        .func       (func),
        .vote_stall (vote_stall),
        .cmd        (cmd),
        .status     (status)
    );

    vbr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .interval      (interval),
        .tonality      (tonality),
        .rank_stall    (rank_stall),
        .rank_valid    (rank_valid),
        .best_tonality (best_tonality),
        .best_segment  (best_segment),
        .top_sum       (top_sum)
    );

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> rank_valid)
        else $error("result not presented after emit");

    a_finish_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        vote_valid && !vote_stall && func |=> vote_stall)
        else $error("finish beat did not start the scan");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.vote_en, cmd.pick_en, cmd.emit, cmd.lane_clr}))
        else $error("conflicting datapath commands");

    a_tonality_range: assert property (@(posedge clk) disable iff (!rst_n)
        rank_valid |-> (best_tonality >= 4'd1) && (best_tonality <= 4'd12))
        else $error("best tonality out of range");

endmodule

`default_nettype wire

### rtl/vbr_lane.sv
`default_nettype none

module vbr_lane (
    input  logic                clk,
    input  logic                clr,
    input  logic                ins,
    input  vbr_pkg::count_t     cand,
    input  vbr_pkg::addr_t      cand_addr,
    output vbr_pkg::lane_sum_t  sum,
    output vbr_pkg::addr_t      first
);
    import vbr_pkg::*;

    count_t    slot_reg  [TOP_SEGMENTS];
    count_t    slot_next [TOP_SEGMENTS];
    count_t    prev      [TOP_SEGMENTS];
    lane_sum_t sum_reg;
    lane_sum_t sum_next;
    addr_t     first_reg;
    addr_t     first_next;
    logic [SUM_W:0] sum_wide;

    // The slots stay sorted, largest first. A candidate only passes a slot
    // it strictly exceeds, so earlier intervals win among equal counts.
    for (genvar j = 0; j < TOP_SEGMENTS; j++) begin : g_prev
        if (j == 0) begin : g_top
            assign prev[j] = '1;
        end
        else begin : g_rest
            assign prev[j] = slot_reg[j-1];
        end
    end

    always_comb
    begin
        for (int j = 0; j < TOP_SEGMENTS; j++)
        begin
            if (slot_reg[j] >= cand)
                slot_next[j] = slot_reg[j];
            else if (j == 0 || prev[j] >= cand)
                slot_next[j] = cand;
            else
                slot_next[j] = prev[j];
        end
        // The running sum swaps the dropped bottom slot for the candidate.
        sum_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(cand)
                   - (SUM_W+1)'(slot_reg[TOP_SEGMENTS-1]);
        if (cand > slot_reg[TOP_SEGMENTS-1])
            sum_next = sum_wide[SUM_W-1:0];
        else
            sum_next = sum_reg;
        if (cand > slot_reg[0])
            first_next = cand_addr;
        else
            first_next = first_reg;
    end

    // Lanes are cleared by command at the start of every finish.
    always_ff @(posedge clk)
    begin
        if (clr)
        begin
            for (int j = 0; j < TOP_SEGMENTS; j++)
                slot_reg[j] <= '0;
            sum_reg   <= '0;
            first_reg <= '0;
        end
        else if (ins)
        begin
            for (int j = 0; j < TOP_SEGMENTS; j++)
                slot_reg[j] <= slot_next[j];
            sum_reg   <= sum_next;
            first_reg <= first_next;
        end
    end

    assign sum   = sum_reg;
    assign first = first_reg;

endmodule

`default_nettype wire

### rtl/vbr_dp.sv
`default_nettype none

module vbr_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vbr_pkg::cmd_t                   cmd,
    output vbr_pkg::status_t                status,
    input  logic [vbr_pkg::IVL_W-1:0]       interval,
    input  logic [vbr_pkg::TON_W-1:0]       tonality,
    input  logic                            rank_stall,
    output logic                            rank_valid,
    output logic [vbr_pkg::TON_W-1:0]       best_tonality,
    output logic [vbr_pkg::IVL_W-1:0]       best_segment,
    output logic [vbr_pkg::SUM_OUT_W-1:0]   top_sum
);
    import vbr_pkg::*;

    logic [ROW_W-1:0] mem [INTERVALS];
    logic [INTERVALS-1:0] row_valid_reg;

    logic             s2_act_reg;
    addr_t            s2_addr_reg;
    ton_t             s2_ton_reg;
    logic [ROW_W-1:0] rd_reg;
    logic             rv_reg;
    logic             hit_reg;
    logic [ROW_W-1:0] fwd_reg;
    addr_t            ins_addr_reg;

    logic             in_range;
    addr_t            vote_addr;
    addr_t            rd_addr;
    logic [ROW_W-1:0] cur_row;
    logic [ROW_W-1:0] new_row;
    count_t           cur_cnt;

    lane_sum_t lane_sum   [TONES];
    addr_t     lane_first [TONES];

    lane_sum_t best_sum_reg;
    ton_t      best_t_reg;
    addr_t     best_seg_reg;

    logic                 rank_valid_reg;
    logic [TON_W-1:0]     best_tonality_reg;
    logic [IVL_W-1:0]     best_segment_reg;
    logic [SUM_OUT_W-1:0] top_sum_reg;
    logic [EXT_W-1:0]     sum_ext;

    assign in_range  = (32'(interval) < INTERVALS) && (32'(tonality) < TONES);
    assign vote_addr = ADDR_W'(interval);
    assign rd_addr   = cmd.vote_en ? vote_addr : cmd.scan_addr;

    // A vote reading the row that the previous vote writes at the same edge
    // takes the forwarded row; rows never written since the last clear read
    // as zero.
    assign cur_row = hit_reg ? fwd_reg : (rv_reg ? rd_reg : '0);

    always_comb
    begin
        cur_cnt = cur_row[32'(s2_ton_reg) * COUNT_WIDTH +: COUNT_WIDTH];
        new_row = cur_row;
        if (cur_cnt != '1)
            new_row[32'(s2_ton_reg) * COUNT_WIDTH +: COUNT_WIDTH] = cur_cnt + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (s2_act_reg)
            mem[s2_addr_reg] <= new_row;
        rd_reg       <= mem[rd_addr];
        rv_reg       <= row_valid_reg[rd_addr];
        fwd_reg      <= new_row;
        s2_addr_reg  <= vote_addr;
        s2_ton_reg   <= tonality;
        ins_addr_reg <= cmd.scan_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_act_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            s2_act_reg <= cmd.vote_en && in_range;
            hit_reg    <= s2_act_reg && cmd.vote_en && (s2_addr_reg == vote_addr);
            if (cmd.emit)
                row_valid_reg <= '0;
            else if (s2_act_reg)
                row_valid_reg[s2_addr_reg] <= 1'b1;
        end
    end

    for (genvar t = 0; t < TONES; t++) begin : g_lane
        vbr_lane u_lane (
            .clk       (clk),
            .clr       (cmd.lane_clr),
            .ins       (cmd.ins_en),
            .cand      (cur_row[t*COUNT_WIDTH +: COUNT_WIDTH]),
            .cand_addr (ins_addr_reg),
            .sum       (lane_sum[t]),
            .first     (lane_first[t])
        );
    end

    // One tonality per cycle; only a strictly larger sum replaces the best.
    always_ff @(posedge clk)
    begin
        if (cmd.pick_en && (cmd.pick_first || lane_sum[cmd.pick_idx] > best_sum_reg))
        begin
            best_sum_reg <= lane_sum[cmd.pick_idx];
            best_t_reg   <= cmd.pick_idx;
            best_seg_reg <= lane_first[cmd.pick_idx];
        end
    end

    assign sum_ext = EXT_W'(best_sum_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            best_tonality_reg <= best_t_reg + 1'b1;
            best_segment_reg  <= IVL_W'(best_seg_reg);
            if (sum_ext > EXT_W'(SUM_MAX))
                top_sum_reg <= SUM_MAX;
            else
                top_sum_reg <= sum_ext[SUM_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rank_valid_reg <= 1'b0;
        else if (cmd.emit)
            rank_valid_reg <= 1'b1;
        else if (!rank_stall)
            rank_valid_reg <= 1'b0;
    end

    assign status.out_busy = rank_valid_reg && rank_stall;
    assign rank_valid      = rank_valid_reg;
    assign best_tonality   = best_tonality_reg;
    assign best_segment    = best_segment_reg;
    assign top_sum         = top_sum_reg;

endmodule

`default_nettype wire

### rtl/vbr_ctrl.sv
`default_nettype none

module vbr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vote_valid,
    input  logic              func,
    output logic              vote_stall,
    output vbr_pkg::cmd_t     cmd,
    input  vbr_pkg::status_t  status
);
    import vbr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_FLUSH = 5'b00100,
        ST_PICK  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    ton_t              ton_reg, ton_next;
    logic              ins_reg;

    logic accept;

    assign vote_stall = (state_reg != ST_IDLE);
    assign accept     = vote_valid && !vote_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ton_next   = ton_reg;

        cmd            = '0;
        cmd.scan_addr  = ADDR_W'(cnt_reg);
        cmd.ins_en     = ins_reg;
        cmd.pick_idx   = ton_reg;
        cmd.pick_first = (ton_reg == '0);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !func)
                    cmd.vote_en = 1'b1;
                if (accept && func)
                begin
                    cmd.lane_clr = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(INTERVALS - 1))
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                ton_next   = '0;
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.pick_en = 1'b1;
                ton_next    = ton_reg + 1'b1;
                if (ton_reg == TON_W'(TONES - 1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ton_reg   <= '0;
            ins_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ton_reg   <= ton_next;
            // Row data arrives in the cycle after its scan read.
            ins_reg   <= (state_reg == ST_SCAN);
        end
    end

endmodule

`default_nettype wire
